// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int PAYLOAD_W   = 32;
   localparam int OCC_W       = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 8;
   localparam int WIDE_W      = 64;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } deq_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } deq_status_type;

   // Per-cycle command broadcast to every cell, already qualified by full/empty.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } deq_cmd_type;

endpackage

// ===== design/deq_cell.sv =====
// One storage cell of the queue chain: an entry and its valid bit.
`timescale 1ns / 1ps
module deq_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  deq_pkg::deq_cmd_type    cmd,
   input  logic [VALUE_WIDTH-1:0]  push_value,
   input  logic [VALUE_WIDTH-1:0]  left_data,
   input  logic                    left_valid,
   input  logic [VALUE_WIDTH-1:0]  right_data,
   input  logic                    right_valid,
   output logic [VALUE_WIDTH-1:0]  data,
   output logic                    valid,
   output logic [VALUE_WIDTH-1:0]  tail_data
);
   import deq_pkg::*;

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;
   logic                   valid_ff;
   logic                   valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (cmd.push_front) begin
         // whole row moves one cell towards the back
         data_in  = left_data;
         valid_in = left_valid;
      end else if (cmd.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (cmd.push_back) begin
         // first empty cell behind a filled one takes the new entry
         if (!valid_ff && left_valid) begin
            data_in  = push_value;
            valid_in = 1'b1;
         end
      end else if (cmd.pop_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign tail_data = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

// ===== design/double_ended_queue_top.sv =====
// Top level of the double-ended queue built as a chain of entry cells.
//
// Usage:
//   req_* carries one operation per beat: req_tuser holds the kind (push
//   front, push back, pop front, pop back) and req_tdata the value to push.
//   rsp_* returns exactly one beat per operation with the popped value, the
//   occupancy after the operation and a status (ok, empty pop, full push).
//   Entries sit in a row of DEPTH cells, front in cell 0; a front push or pop
//   shifts the whole row by one cell, while a back push or pop acts
//   on the cell at the tail of the occupied run.
//   The response is registered in the cycle that takes the operation.
//   Throughput is one operation per clock while rsp_tready is high; the cell
//   update and the tail selection across the row are both done in that cycle.
//   The response register is refilled in the cycle it is taken, so the
//   request side keeps flowing while rsp_tready is high. When the receiver
//   stalls, the response holds and req_tready drops until it is taken.
//   Reset clears all valid bits, the count and the response valid flag; the
//   queue is empty and ready in the first cycle after reset.
`timescale 1ns / 1ps
module double_ended_queue_top #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [deq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [31:0] push_value
   input  logic [deq_pkg::REQ_TUSER_W-1:0]   req_tuser,  // [1:0] kind, [7:2] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [31:0] pop_value,
                                                         // [36:32] occupancy, [39:37] zero
   output logic [deq_pkg::RSP_TUSER_W-1:0]   rsp_tuser   // [1:0] status, [7:2] zero
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                   accept;
   deq_kind_type           kind;
   logic [WIDE_W-1:0]      push_wide;
   logic [VALUE_WIDTH-1:0] push_w;
   logic                   full;
   logic                   empty;
   deq_cmd_type            cmd;
   deq_status_type         status;
   logic [VALUE_WIDTH-1:0] pop_w;
   logic [VALUE_WIDTH-1:0] tail_or;
   logic [WIDE_W-1:0]      pop_wide;
   logic [WIDE_W-1:0]      count_wide;

   logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
   logic                   cell_valid [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_tail [DEPTH];

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic [PAYLOAD_W-1:0]   rsp_value_ff;
   logic [OCC_W-1:0]       rsp_occ_ff;
   deq_status_type         rsp_status_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign kind       = deq_kind_type'(req_tuser[KIND_W-1:0]);
   assign push_wide  = WIDE_W'(req_tdata[PAYLOAD_W-1:0]);
   assign push_w     = push_wide[VALUE_WIDTH-1:0];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      cmd      = '0;
      status   = ST_OK;
      count_in = count_ff;
      unique case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.push_front = accept && (kind == KIND_PUSH_FRONT);
               cmd.push_back  = accept && (kind == KIND_PUSH_BACK);
               count_in       = count_ff + CNT_W'(1);
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cmd.pop_front = accept && (kind == KIND_POP_FRONT);
               cmd.pop_back  = accept && (kind == KIND_POP_BACK);
               count_in      = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [VALUE_WIDTH-1:0] left_data;
         logic                   left_valid;
         logic [VALUE_WIDTH-1:0] right_data;
         logic                   right_valid;

         // cell 0 sees the incoming value as its front neighbour
         if (gi == 0) begin : g_head
            assign left_data  = push_w;
            assign left_valid = 1'b1;
         end else begin : g_mid
            assign left_data  = cell_data[gi-1];
            assign left_valid = cell_valid[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
         end else begin : g_inner
            assign right_data  = cell_data[gi+1];
            assign right_valid = cell_valid[gi+1];
         end

         deq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .push_value  (push_w),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[gi]),
            .valid       (cell_valid[gi]),
            .tail_data   (cell_tail[gi])
         );
      end
   endgenerate

   // only the tail cell drives a non-zero word
   always_comb begin
      tail_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_or = tail_or | cell_tail[i];
      end
   end

   always_comb begin
      pop_w = '0;
      if (status == ST_OK) begin
         if (kind == KIND_POP_FRONT) begin
            pop_w = cell_data[0];
         end else if (kind == KIND_POP_BACK) begin
            pop_w = tail_or;
         end
      end
   end

   assign pop_wide   = WIDE_W'(pop_w);
   assign count_wide = WIDE_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= pop_wide[PAYLOAD_W-1:0];
         rsp_occ_ff    <= count_wide[OCC_W-1:0];
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - PAYLOAD_W - OCC_W)'(0), rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = {(RSP_TUSER_W - STATUS_W)'(0), rsp_status_ff};

endmodule

// ===== design/deq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
module deq_checker #(
   parameter int DEPTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [deq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [deq_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import deq_pkg::*;

   logic [WIDE_W-1:0] depth_wide;
   assign depth_wide = WIDE_W'(DEPTH);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a new response only follows an accepted request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("response without request");

   // empty pop leaves an empty queue and returns zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[STATUS_W-1:0] == ST_EMPTY |->
         rsp_tdata[PAYLOAD_W-1:0] == '0 && rsp_tdata[PAYLOAD_W+OCC_W-1:PAYLOAD_W] == '0)
      else $error("empty pop with data or occupancy");

   // dropped push only happens with a full queue
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[STATUS_W-1:0] == ST_FULL |->
         rsp_tdata[PAYLOAD_W+OCC_W-1:PAYLOAD_W] == depth_wide[OCC_W-1:0])
      else $error("full status below depth");

endmodule

bind double_ended_queue_top deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (.*);

// ===== tb/sv/double_ended_queue_top_test.sv =====
// Self-checking testbench for the double-ended queue: directed, back-pressure and random runs.
`timescale 1ns / 1ps
module double_ended_queue_top_test;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] pop_value;
      deq_status_type       status;
      logic [OCC_W-1:0]     occupancy;
   } deq_outcome_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_mode_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // predictor state
   logic [PAYLOAD_W-1:0] ring_words [QUEUE_DEPTH];
   logic [3:0]           head_slot  = '0;
   logic [OCC_W-1:0]     held_count = '0;

   deq_outcome_type pending_outcomes [$];

   int             fail_count   = 0;
   int             cycle_count  = 0;
   int             push_count   = 0;
   int             pop_count    = 0;
   int             full_drops   = 0;
   int             empty_pops   = 0;
   int             beats_checked = 0;
   int             burst_left   = 0;
   bit             gaps_on      = 1'b0;
   stall_mode_type stall_mode   = STALL_NONE;
   int             hold_request = 0;
   int             hold_left    = 0;
   int             pattern_step = 0;

   double_ended_queue_top #(
      .DEPTH       (QUEUE_DEPTH),
      .VALUE_WIDTH (PAYLOAD_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Ring arithmetic relies on the 4-bit slot index wrapping at 16 entries.
   function automatic deq_outcome_type apply_op(input deq_kind_type kind,
                                                input logic [PAYLOAD_W-1:0] value);
      deq_outcome_type res;
      logic [3:0]      slot;
      res.pop_value = '0;
      res.status    = ST_OK;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (held_count == QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else if (kind == KIND_PUSH_FRONT) begin
               head_slot = head_slot - 4'd1;
               ring_words[head_slot] = value;
               held_count = held_count + 1'b1;
            end else begin
               slot = head_slot + held_count[3:0];
               ring_words[slot] = value;
               held_count = held_count + 1'b1;
            end
         end
         default: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else if (kind == KIND_POP_FRONT) begin
               res.pop_value = ring_words[head_slot];
               head_slot = head_slot + 4'd1;
               held_count = held_count - 1'b1;
            end else begin
               slot = head_slot + 4'(held_count - 1'b1);
               res.pop_value = ring_words[slot];
               held_count = held_count - 1'b1;
            end
         end
      endcase
      res.occupancy = held_count;
      return res;
   endfunction

   // Response check first: a beat leaving this edge belongs to an earlier request.
   always @(posedge clock) begin
      deq_outcome_type want;
      deq_kind_type    kind;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (pending_outcomes.size() == 0) begin
               $error("response beat with no outstanding operation");
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tdata[31:0] !== want.pop_value) begin
                  $error("pop_value: expected %h, got %h", want.pop_value, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[36:32] !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_tdata[36:32]);
                  fail_count++;
               end
               if (rsp_tuser[1:0] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[1:0]);
                  fail_count++;
               end
               if (rsp_tdata[39:37] !== 3'b0 || rsp_tuser[7:2] !== 6'b0) begin
                  $error("padding: expected 0, got tdata %h tuser %h", rsp_tdata[39:37],
                         rsp_tuser[7:2]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            kind = deq_kind_type'(req_tuser[1:0]);
            want = apply_op(kind, req_tdata[31:0]);
            if (want.status == ST_FULL) full_drops++;
            else if (want.status == ST_EMPTY) empty_pops++;
            else if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) push_count++;
            else pop_count++;
            pending_outcomes.push_back(want);
         end
      end
   end

   // Receiver: a requested hold-off takes priority over the running pattern.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      pattern_step++;
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         case (stall_mode)
            STALL_NONE:    rsp_tready = 1'b1;
            STALL_RANDOM:  rsp_tready = ($urandom_range(0, 9) >= 3);
            STALL_PATTERN: rsp_tready = ((pattern_step % 7) < 4);
            default:       rsp_tready = 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high from one beat to the next inside a burst
   task automatic send_op(input deq_kind_type kind, input logic [PAYLOAD_W-1:0] value);
      @(negedge clock);
      if (gaps_on && burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = {6'b0, kind};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_queue();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [PAYLOAD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << $urandom_range(0, 31);
         3:       return ~(32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      int i;
      send_op(KIND_POP_FRONT, 32'h1234_5678);
      send_op(KIND_POP_BACK, '1);
      send_op(KIND_PUSH_FRONT, '0);          // front slot wraps below zero
      send_op(KIND_PUSH_BACK, '1);
      send_op(KIND_POP_BACK, '0);
      send_op(KIND_POP_FRONT, '0);
      for (i = 0; i < QUEUE_DEPTH; i++) begin
         if (i % 2 == 0) send_op(KIND_PUSH_FRONT, 32'h8000_0000 >> i);
         else send_op(KIND_PUSH_BACK, ~(32'h1 << i));
      end
      send_op(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
      send_op(KIND_PUSH_BACK, 32'hCAFE_F00D);
      send_op(KIND_POP_FRONT, '0);
      send_op(KIND_POP_BACK, '0);
      drain_queue();
   endtask

   // Chunks of push-heavy and pop-heavy traffic swing the queue between full and empty.
   task automatic test_random_walk(input int count);
      int push_pct;
      int chunk_left;
      deq_kind_type kind;
      chunk_left = 0;
      push_pct = 50;
      repeat (count) begin
         if (chunk_left == 0) begin
            chunk_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         chunk_left--;
         if ($urandom_range(0, 99) < push_pct)
            kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
         else
            kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
         send_op(kind, pick_value());
      end
      drain_queue();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      hold_request = 80;
      test_random_walk(40);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      stall_mode = STALL_NONE;
      test_directed();

      stall_mode = STALL_RANDOM;
      test_backpressure();

      gaps_on = 1'b0;
      stall_mode = STALL_NONE;
      test_random_walk(450);

      gaps_on = 1'b1;
      stall_mode = STALL_RANDOM;
      test_random_walk(450);

      gaps_on = 1'b1;
      stall_mode = STALL_PATTERN;
      test_random_walk(450);

      gaps_on = 1'b0;
      stall_mode = STALL_RANDOM;
      test_random_walk(450);

      drain_queue();
      repeat (4) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d expected responses never arrived", pending_outcomes.size());
         fail_count++;
      end
      $display("Checked %0d response beats: %0d pushes, %0d pops,", beats_checked,
               push_count, pop_count);
      $display("%0d pushes dropped when full, %0d pops on empty, %0d errors", full_drops,
               empty_pops, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
